@@ rtl/asbs_pkg.sv @@
// Shared constants, control/status structs and the quarter-wave sine series
// for the additive sine bank synthesizer. No dependencies.
package asbs_pkg;

  localparam int DEF_MAX_TONES    = 8192;
  localparam int DEF_SINE_ENTRIES = 1024;

  localparam int SAMPLE_RATE = 44100;
  // 999999 mod 44100: per-tone time advance
  localparam int TONE_STEP   = 29799;
  // floor(2^32 / 44100) and floor(2^24 / 255) for reciprocal division
  localparam int RECIP_FS    = 97391;
  localparam int RECIP_255   = 65793;
  localparam int FULL_SCALE  = 32767;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [14:0] BASE_FREQ_RST    = 15'd500;
  localparam logic [13:0] ACTIVE_TONES_RST = 14'd7000;

  localparam logic REG_BASE_FREQ    = 1'b0;
  localparam logic REG_ACTIVE_TONES = 1'b1;

  // (2n)(2n+1) for n = 1..8
  localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic clr_step;
    logic wr_amp;
    logic load_t;
    logic mod_step;
    logic walk_start;
    logic walk_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic walk_last;
    logic tones_zero;
    logic pipe_empty;
    logic sum_zero;
    logic div_done;
    logic out_busy;
  } stat_t;

  // Q30 sine on [0, pi/2], elaboration only
  function automatic longint unsigned quarter_sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if (n % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return sum;
  endfunction

endpackage

@@ rtl/asbs_ctrl.sv @@
// Sequencer for the additive sine bank: clear pass, time reduction, tone
// walk, drain, divide and result hand-off. Depends on asbs_pkg.
module asbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  input  asbs_pkg::stat_t stat,
  output asbs_pkg::cmd_t  cmd
);
  import asbs_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MOD   = 8'b0000_0100,
    ST_WINIT = 8'b0000_1000,
    ST_WALK  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.wr_amp = accept & ~in_action;
        cmd.load_t = accept & in_action;
        if (accept & in_action) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) state_nxt = ST_WINIT;
      end
      ST_WINIT: begin
        cmd.walk_start = 1'b1;
        state_nxt = stat.tones_zero ? ST_DRAIN : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          if (stat.sum_zero) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

@@ rtl/asbs_dp.sv @@
// Datapath: amplitude memory, tone phase pipeline with sine ROM, accumulators,
// bit-serial divider and output register. Depends on asbs_pkg.
module asbs_dp #(
  parameter int MAX_TONES    = asbs_pkg::DEF_MAX_TONES,
  parameter int SINE_ENTRIES = asbs_pkg::DEF_SINE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  asbs_pkg::cmd_t     cmd,
  output asbs_pkg::stat_t    stat,
  input  logic [14:0]        base_freq,
  input  logic [13:0]        active_tones,
  input  logic [12:0]        in_tone_index,
  input  logic [7:0]         in_amplitude,
  input  logic [31:0]        in_sample_time,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_sample_out,
  output logic               out_silent_flag
);
  import asbs_pkg::*;

  localparam int AW     = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int TW     = $clog2(MAX_TONES + 1);
  localparam int IW     = $clog2(SINE_ENTRIES);
  localparam int SUM_W  = $clog2(MAX_TONES * 255 + 1);
  localparam int ACC_W  = $clog2(MAX_TONES * FULL_SCALE + 1) + 1;
  localparam int DVD_W  = ACC_W - 1 + 8;
  localparam int CNT_W  = $clog2(((DVD_W > 32) ? DVD_W : 32) + 1);
  localparam int NSTG   = 13;
  localparam int MOD_STEPS = 3;

  typedef logic signed [15:0] rom_t [SINE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t rom;
    longint unsigned k4, quad, rm, r, x, s, mag;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      k4   = longint'(k) * 4;
      quad = k4 / SINE_ENTRIES;
      rm   = k4 - quad * SINE_ENTRIES;
      r    = (quad % 2 == 1) ? (SINE_ENTRIES - rm) : rm;
      x    = (HALF_PI_Q30 * r) / SINE_ENTRIES;
      s    = quarter_sine_q30(x);
      mag  = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (mag > FULL_SCALE) mag = FULL_SCALE;
      rom[k] = (quad >= 2) ? -16'(mag) : 16'(mag);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [7:0] amp_mem [MAX_TONES];

  // control registers
  logic [AW-1:0]    j_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NSTG:1]    v_r;
  logic             out_valid_r;

  // walk and arithmetic state
  logic [31:0]             t_r;
  logic [16:0]             tq_r;
  logic [31:0]             tm_prod_r;
  logic [15:0]             rem_r, tm_r, fr_r;
  logic [TW-1:0]           tones_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [SUM_W-1:0]        sum_r;
  logic [DVD_W-1:0]        dvd_r;
  logic [SUM_W-1:0]        drem_r;
  logic                    neg_r;
  logic signed [15:0]      out_sample_r;
  logic                    out_silent_r;

  // pipeline stages
  logic [31:0] s1_x, s2_x, s3_x;
  logic [7:0]  s1_a, s2_a, s3_a, s4_a, s5_a, s6_a, s7_a, s8_a, s9_a;
  logic [16:0] s2_q, s6_q, s7_q;
  logic [31:0] s3_m, s5_p, s6_p, s7_p, s7_m;
  logic [15:0] s4_ph;
  logic [IW-1:0] s8_idx;
  logic signed [15:0] s9_sn;
  logic [22:0] s10_y, s11_y, s12_y;
  logic        s10_neg, s11_neg, s12_neg;
  logic [15:0] s11_q, s12_q;
  logic [22:0] s12_m;
  logic signed [15:0] s13_term;

  // combinational helpers
  logic [TW-1:0]  tones_lim;
  logic [31:0]    tone_w;
  logic [48:0]    t_qprod;
  logic [16:0]    t_d;
  logic [16:0]    tm_add;
  logic [48:0]    q2_prod, q6_prod;
  logic [16:0]    d3;
  logic [16:0]    d7;
  logic [15:0]    sn_mag;
  logic [38:0]    q11_prod;
  logic [8:0]     d12;
  logic [ACC_W-2:0] acc_mag;
  logic [SUM_W:0]   drem_ext;
  logic signed [15:0] res_sat;

  assign tones_lim = (32'(active_tones) > 32'(MAX_TONES)) ? TW'(MAX_TONES)
                                                          : TW'(active_tones);
  assign tone_w  = 32'(in_tone_index);
  assign t_qprod = 49'(t_r) * 49'(RECIP_FS);
  assign t_d     = 17'(t_r - tm_prod_r);
  assign tm_add  = 17'(tm_r) + 17'(TONE_STEP);
  assign q2_prod = 49'(s1_x) * 49'(RECIP_FS);
  assign d3      = 17'(s3_x - s3_m);
  assign q6_prod = 49'(s5_p) * 49'(RECIP_FS);
  assign d7      = 17'(s7_p - s7_m);
  assign sn_mag  = s9_sn[15] ? 16'(-s9_sn) : 16'(s9_sn);
  assign q11_prod = 39'(s10_y) * 39'(RECIP_255);
  assign d12     = 9'(s12_y - s12_m);
  assign acc_mag = acc_r[ACC_W-1] ? (ACC_W-1)'(-acc_r) : (ACC_W-1)'(acc_r);
  assign drem_ext = {drem_r, dvd_r[DVD_W-1]};

  always_comb begin
    if (!neg_r) begin
      res_sat = (dvd_r > DVD_W'(32767)) ? 16'sd32767 : signed'(dvd_r[15:0]);
    end else begin
      res_sat = (dvd_r >= DVD_W'(32768)) ? -16'sd32768 : signed'(-dvd_r[15:0]);
    end
  end

  assign stat.clr_last   = (32'(j_r) == 32'(MAX_TONES - 1));
  assign stat.mod_done   = (cnt_r == CNT_W'(MOD_STEPS - 1));
  assign stat.walk_last  = ((TW + 1)'(j_r) == (TW + 1)'(tones_r) - (TW + 1)'(1));
  assign stat.tones_zero = (tones_lim == '0);
  assign stat.pipe_empty = ~(|v_r);
  assign stat.sum_zero   = (sum_r == '0);
  assign stat.div_done   = (cnt_r == CNT_W'(DVD_W - 1));
  assign stat.out_busy   = out_valid_r & ~out_ready;

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_silent_flag = out_silent_r;

  // amplitude memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      amp_mem[j_r] <= '0;
    end else if (cmd.wr_amp && tone_w < 32'(MAX_TONES)) begin
      amp_mem[tone_w[AW-1:0]] <= in_amplitude;
    end
    s1_a <= amp_mem[j_r];
  end

  always_ff @(posedge clk) begin
    s8_a <= s7_a;
    s9_sn <= SINE_ROM[s8_idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r         <= '0;
      cnt_r       <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r <= {v_r[NSTG-1:1], cmd.walk_step};
      if (cmd.clr_step || cmd.walk_step) j_r <= j_r + AW'(1);
      else if (cmd.walk_start)           j_r <= '0;
      if (cmd.load_t || cmd.div_start)       cnt_r <= '0;
      else if (cmd.mod_step || cmd.div_step) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.load_out)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_t) begin
      t_r <= in_sample_time;
    end else if (cmd.mod_step) begin
      // t mod fs: reciprocal estimate, back-multiply, one correction
      tq_r      <= t_qprod[48:32];
      tm_prod_r <= 32'(tq_r) * 32'(SAMPLE_RATE);
      rem_r     <= (t_d >= 17'(SAMPLE_RATE)) ? 16'(t_d - 17'(SAMPLE_RATE))
                                             : t_d[15:0];
    end

    if (cmd.walk_start) begin
      tm_r    <= rem_r;
      fr_r    <= 16'(base_freq);
      tones_r <= tones_lim;
      acc_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (cmd.walk_step) begin
        tm_r <= (tm_add >= 17'(SAMPLE_RATE)) ? 16'(tm_add - 17'(SAMPLE_RATE))
                                             : tm_add[15:0];
        fr_r <= (fr_r == 16'(SAMPLE_RATE - 1)) ? '0 : fr_r + 16'd1;
      end
      if (v_r[1])    sum_r <= sum_r + SUM_W'(s1_a);
      if (v_r[NSTG]) acc_r <= acc_r + ACC_W'(s13_term);
    end

    // tone pipeline
    s1_x  <= 32'(tm_r) * 32'(fr_r);
    s2_x  <= s1_x;  s2_q <= q2_prod[48:32]; s2_a <= s1_a;
    s3_x  <= s2_x;  s3_m <= 32'(s2_q) * 32'(SAMPLE_RATE); s3_a <= s2_a;
    s4_ph <= (d3 >= 17'(SAMPLE_RATE)) ? 16'(d3 - 17'(SAMPLE_RATE)) : d3[15:0];
    s4_a  <= s3_a;
    s5_p  <= 32'(s4_ph) * 32'(SINE_ENTRIES); s5_a <= s4_a;
    s6_p  <= s5_p;  s6_q <= q6_prod[48:32]; s6_a <= s5_a;
    s7_p  <= s6_p;  s7_q <= s6_q; s7_m <= 32'(s6_q) * 32'(SAMPLE_RATE); s7_a <= s6_a;
    s8_idx <= IW'(s7_q + ((d7 >= 17'(SAMPLE_RATE)) ? 17'd1 : 17'd0));
    s9_a  <= s8_a;
    s10_y <= 23'(s9_a) * 23'(sn_mag); s10_neg <= s9_sn[15];
    s11_q <= 16'(q11_prod[38:24]); s11_y <= s10_y; s11_neg <= s10_neg;
    s12_m <= 23'(s11_q) * 23'd255; s12_q <= s11_q; s12_y <= s11_y;
    s12_neg <= s11_neg;
    s13_term <= s12_neg ? -signed'(s12_q + ((d12 >= 9'd255) ? 16'd1 : 16'd0))
                        : signed'(s12_q + ((d12 >= 9'd255) ? 16'd1 : 16'd0));

    // restoring divider: quotient bits shift into the dividend register
    if (cmd.div_start) begin
      dvd_r  <= (DVD_W'(acc_mag) << 8) - DVD_W'(acc_mag);
      drem_r <= '0;
      neg_r  <= acc_r[ACC_W-1];
    end else if (cmd.div_step) begin
      if (drem_ext >= (SUM_W + 1)'(sum_r)) begin
        drem_r <= SUM_W'(drem_ext - (SUM_W + 1)'(sum_r));
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        drem_r <= drem_ext[SUM_W-1:0];
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end

    if (cmd.load_out) begin
      out_sample_r <= stat.sum_zero ? 16'sd0 : res_sat;
      out_silent_r <= stat.sum_zero;
    end
  end

endmodule

@@ rtl/additive_sine_bank_synth_top.sv @@
// Additive sine bank synthesizer: after reset a clearing pass zeroes every
// entry of the amplitude memory with in_ready low.
// An amplitude write leaves in_ready high. A sample request is served by
// reducing the time index, a setup step, a walk of one tone per cycle over
// N tones (N = active_tones, capped at MAX_TONES), a drain, the divide and a load.
// A silent row skips the divide; the next request is taken as out_valid rises.
// Holds the configuration registers; depends on asbs_pkg, asbs_ctrl, asbs_dp.
module additive_sine_bank_synth_top #(
  parameter int MAX_TONES    = asbs_pkg::DEF_MAX_TONES,
  parameter int SINE_ENTRIES = asbs_pkg::DEF_SINE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [12:0]        in_tone_index,
  input  logic [7:0]         in_amplitude,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  output logic               out_silent_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_wdata
);
  import asbs_pkg::*;

  logic [14:0] base_freq_r;
  logic [13:0] active_tones_r;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r    <= BASE_FREQ_RST;
      active_tones_r <= ACTIVE_TONES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_FREQ:    base_freq_r    <= cfg_wdata;
        REG_ACTIVE_TONES: active_tones_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  asbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  asbs_dp #(
    .MAX_TONES    (MAX_TONES),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .base_freq       (base_freq_r),
    .active_tones    (active_tones_r),
    .in_tone_index   (in_tone_index),
    .in_amplitude    (in_amplitude),
    .in_sample_time  (in_sample_time),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out),
    .out_silent_flag (out_silent_flag)
  );

endmodule
